// File: rtl/newton_divided_difference_interpolator_unit_assert.svh
// assertion macros shared by the checker
`ifndef NEWTON_DIVIDED_DIFFERENCE_INTERPOLATOR_UNIT_ASSERT_SVH
`define NEWTON_DIVIDED_DIFFERENCE_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define NDD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ndd check failed");

// next-cycle implication, off during reset
`define NDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ndd check failed");

// next-cycle implication, always on
`define NDD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ndd check failed");

`endif

// File: rtl/ndd_pkg.sv
package ndd_pkg;

  localparam int NDD_MAX_NODES = 8;

  localparam int Q_W    = 32;
  localparam int FRAC_W = 16;
  localparam int DIF_W  = Q_W + 1;
  localparam int DVD_W  = DIF_W + FRAC_W;
  localparam int PROD_W = 2 * Q_W;
  localparam int TRQ_W  = PROD_W - FRAC_W;
  localparam int SUM_W  = 56;

  localparam logic [Q_W-1:0] Q_ONE = Q_W'(65536);

  // request kinds on the input tuser
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_EVAL  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_REP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_FULL,
    OP_NONODE,
    OP_EVAL_START,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_RD_A,
    OP_RD_B,
    OP_DIV_START,
    OP_DIV_WR,
    OP_REP,
    OP_SUM_RD0,
    OP_SUM_INIT,
    OP_SUM_RD,
    OP_SUM_D,
    OP_SUM_M1,
    OP_SUM_T,
    OP_SUM_M2,
    OP_SUM_ACC,
    OP_FINISH,
    OP_EMIT
  } op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic single;
    logic k_last;
    logic i_eq_j;
    logic j_last;
    logic den_zero;
    logic div_done;
    logic out_free;
  } dp_flags_t;

  // clamp a wide signed value to q16.16
  function automatic logic [Q_W-1:0] sat_q(input logic [SUM_W-1:0] v);
    if (&v[SUM_W-1:Q_W-1] || ~|v[SUM_W-1:Q_W-1]) begin
      return v[Q_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

  // divide a product by 2^16, rounding toward zero
  function automatic logic [TRQ_W-1:0] trunc_q(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] adj;
    adj = p + (p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    return adj[PROD_W-1:FRAC_W];
  endfunction

endpackage

// File: rtl/ndd_ram.sv
module ndd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ndd_divider.sv
module ndd_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ndd_pkg::DVD_W-1:0] dividend,
  input  logic [ndd_pkg::DIF_W-1:0] divisor,
  output logic                      done,
  output logic [ndd_pkg::DVD_W-1:0] quotient
);
  import ndd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIF_W-1:0] rem;
  logic [DIF_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [DIF_W:0]   trial;
  logic [DIF_W:0]   diff;
  logic             ge;

  // one restoring step per cycle
  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = !diff[DIF_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(DVD_W - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (cnt == CNT_W'(DVD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      rem <= ge ? diff[DIF_W-1:0] : trial[DIF_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/ndd_dp.sv
module ndd_dp #(
  parameter int MAX_NODES = ndd_pkg::NDD_MAX_NODES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ndd_pkg::op_t            op,
  output ndd_pkg::dp_flags_t      flags,
  input  logic [ndd_pkg::Q_W-1:0] in_x,
  input  logic [ndd_pkg::Q_W-1:0] in_y,
  input  logic [ndd_pkg::Q_W-1:0] in_eval,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ndd_pkg::Q_W-1:0] out_value,
  output logic [1:0]              out_status
);
  import ndd_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  logic [CW-1:0]     count;
  logic [CW-1:0]     cnt_m1;
  logic [AW-1:0]     k, i, j;
  logic [Q_W-1:0]    eval_x, fi, xi, d, freg, term;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum;
  logic [Q_W-1:0]    res_value;
  logic [1:0]        res_status;
  logic              div_neg;

  // ram ports
  logic           x_we, y_we, f_we;
  logic [AW-1:0]  x_ra, y_ra, f_ra, f_wa;
  logic [Q_W-1:0] x_rd, y_rd, f_rd, f_wd;

  // divider
  logic [DIF_W-1:0] num, den, num_abs, den_abs;
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_q;
  logic [DVD_W:0]   q_signed;
  logic [Q_W-1:0]   q_sat;

  // multiplier
  logic [Q_W-1:0]   ma, mb;
  logic [TRQ_W-1:0] prod_tr;
  logic [DIF_W-1:0] dx;

  assign cnt_m1 = count - CW'(1);

  // node store and working table
  ndd_ram #(.WIDTH(Q_W), .DEPTH(MAX_NODES)) u_xram (
    .clk(clk), .we(x_we), .waddr(count[AW-1:0]), .wdata(in_x), .raddr(x_ra), .rdata(x_rd)
  );
  ndd_ram #(.WIDTH(Q_W), .DEPTH(MAX_NODES)) u_yram (
    .clk(clk), .we(y_we), .waddr(count[AW-1:0]), .wdata(in_y), .raddr(y_ra), .rdata(y_rd)
  );
  ndd_ram #(.WIDTH(Q_W), .DEPTH(MAX_NODES)) u_fram (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
  );

  // address and write selection
  always_comb begin
    x_we = (op == OP_LOAD);
    y_we = (op == OP_LOAD);
    y_ra = k;
    x_ra = i;
    f_ra = i;
    f_we = 1'b0;
    f_wa = i;
    f_wd = q_sat;
    unique case (op)
      OP_RD_B: begin
        x_ra = i - j;
        f_ra = i - AW'(1);
      end
      OP_SUM_RD0: begin
        f_ra = '0;
      end
      OP_SUM_RD: begin
        x_ra = j - AW'(1);
        f_ra = j;
      end
      OP_COPY_WR: begin
        f_we = 1'b1;
        f_wa = k;
        f_wd = y_rd;
      end
      OP_DIV_WR: begin
        f_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // divided difference operands, second pair straight from the rams
  assign num     = {fi[Q_W-1], fi} - {f_rd[Q_W-1], f_rd};
  assign den     = {xi[Q_W-1], xi} - {x_rd[Q_W-1], x_rd};
  assign num_abs = num[DIF_W-1] ? -num : num;
  assign den_abs = den[DIF_W-1] ? -den : den;
  assign div_start = (op == OP_DIV_START);

  ndd_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({num_abs, {FRAC_W{1'b0}}}), .divisor(den_abs),
    .done(div_done), .quotient(div_q)
  );

  // restore the sign and clamp the quotient
  assign q_signed = div_neg ? -{1'b0, div_q} : {1'b0, div_q};
  assign q_sat    = sat_q({{(SUM_W-DVD_W-1){q_signed[DVD_W]}}, q_signed});

  // shared multiplier operands
  always_comb begin
    ma = term;
    mb = d;
    if (op == OP_SUM_M2) begin
      ma = freg;
      mb = term;
    end
  end

  assign prod_tr = trunc_q(prod);
  assign dx      = {eval_x[Q_W-1], eval_x} - {x_rd[Q_W-1], x_rd};

  // status toward the controller
  always_comb begin
    flags.cnt_zero = (count == '0);
    flags.cnt_full = (count == CW'(MAX_NODES));
    flags.single   = (count == CW'(1));
    flags.k_last   = (CW'(k) == cnt_m1);
    flags.i_eq_j   = (i == j);
    flags.j_last   = (CW'(j) == cnt_m1);
    flags.den_zero = (den == '0);
    flags.div_done = div_done;
    flags.out_free = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op == OP_CLEAR) begin
        count <= '0;
      end else if (op == OP_LOAD) begin
        count <= count + CW'(1);
      end
      if (op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_CLEAR, OP_LOAD: begin
        res_value  <= '0;
        res_status <= ST_OK;
      end
      OP_FULL: begin
        res_value  <= '0;
        res_status <= ST_FULL;
      end
      OP_NONODE: begin
        res_value  <= '0;
        res_status <= ST_NONE;
      end
      OP_REP: begin
        res_value  <= '0;
        res_status <= ST_REP;
      end
      OP_EVAL_START: begin
        eval_x <= in_eval;
        k      <= '0;
      end
      OP_COPY_WR: begin
        if (flags.k_last) begin
          j <= AW'(1);
          i <= cnt_m1[AW-1:0];
        end else begin
          k <= k + AW'(1);
        end
      end
      OP_RD_B: begin
        fi <= f_rd;
        xi <= x_rd;
      end
      OP_DIV_START: begin
        div_neg <= num[DIF_W-1] ^ den[DIF_W-1];
      end
      OP_DIV_WR: begin
        if (i == j) begin
          j <= j + AW'(1);
          i <= cnt_m1[AW-1:0];
        end else begin
          i <= i - AW'(1);
        end
      end
      OP_SUM_INIT: begin
        sum  <= {{(SUM_W-Q_W){f_rd[Q_W-1]}}, f_rd};
        term <= Q_ONE;
        j    <= AW'(1);
      end
      OP_SUM_D: begin
        d    <= sat_q({{(SUM_W-DIF_W){dx[DIF_W-1]}}, dx});
        freg <= f_rd;
      end
      OP_SUM_M1, OP_SUM_M2: begin
        prod <= PROD_W'($signed(ma) * $signed(mb));
      end
      OP_SUM_T: begin
        term <= sat_q({{(SUM_W-TRQ_W){prod_tr[TRQ_W-1]}}, prod_tr});
      end
      OP_SUM_ACC: begin
        sum <= sum + {{(SUM_W-TRQ_W){prod_tr[TRQ_W-1]}}, prod_tr};
        if (!flags.j_last) begin
          j <= j + AW'(1);
        end
      end
      OP_FINISH: begin
        res_value  <= sat_q(sum);
        res_status <= ST_OK;
      end
      OP_EMIT: begin
        out_value  <= res_value;
        out_status <= res_status;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/ndd_ctrl.sv
module ndd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         mode,
  output logic               in_ready,
  input  ndd_pkg::dp_flags_t flags,
  output ndd_pkg::op_t       op
);
  import ndd_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_COPY_RD  = 17'h00002,
    S_COPY_WR  = 17'h00004,
    S_RD_A     = 17'h00008,
    S_RD_B     = 17'h00010,
    S_DIV_GO   = 17'h00020,
    S_DIV_WAIT = 17'h00040,
    S_SUM_RD0  = 17'h00080,
    S_SUM_INIT = 17'h00100,
    S_SUM_RD   = 17'h00200,
    S_SUM_D    = 17'h00400,
    S_SUM_M1   = 17'h00800,
    S_SUM_T    = 17'h01000,
    S_SUM_M2   = 17'h02000,
    S_SUM_ACC  = 17'h04000,
    S_FIN      = 17'h08000,
    S_EMIT     = 17'h10000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of one request
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            MODE_LOAD: begin
              op         = flags.cnt_full ? OP_FULL : OP_LOAD;
              state_next = S_EMIT;
            end
            MODE_CLEAR: begin
              op         = OP_CLEAR;
              state_next = S_EMIT;
            end
            MODE_EVAL: begin
              if (flags.cnt_zero) begin
                op         = OP_NONODE;
                state_next = S_EMIT;
              end else begin
                op         = OP_EVAL_START;
                state_next = S_COPY_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_COPY_RD: begin
        op         = OP_COPY_RD;
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        op = OP_COPY_WR;
        if (flags.k_last) begin
          state_next = flags.single ? S_SUM_RD0 : S_RD_A;
        end else begin
          state_next = S_COPY_RD;
        end
      end
      S_RD_A: begin
        op         = OP_RD_A;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        op         = OP_RD_B;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        if (flags.den_zero) begin
          op         = OP_REP;
          state_next = S_EMIT;
        end else begin
          op         = OP_DIV_START;
          state_next = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (flags.div_done) begin
          op         = OP_DIV_WR;
          state_next = (flags.i_eq_j && flags.j_last) ? S_SUM_RD0 : S_RD_A;
        end
      end
      S_SUM_RD0: begin
        op         = OP_SUM_RD0;
        state_next = S_SUM_INIT;
      end
      S_SUM_INIT: begin
        op         = OP_SUM_INIT;
        state_next = flags.single ? S_FIN : S_SUM_RD;
      end
      S_SUM_RD: begin
        op         = OP_SUM_RD;
        state_next = S_SUM_D;
      end
      S_SUM_D: begin
        op         = OP_SUM_D;
        state_next = S_SUM_M1;
      end
      S_SUM_M1: begin
        op         = OP_SUM_M1;
        state_next = S_SUM_T;
      end
      S_SUM_T: begin
        op         = OP_SUM_T;
        state_next = S_SUM_M2;
      end
      S_SUM_M2: begin
        op         = OP_SUM_M2;
        state_next = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        op         = OP_SUM_ACC;
        state_next = flags.j_last ? S_FIN : S_SUM_RD;
      end
      S_FIN: begin
        op         = OP_FINISH;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (flags.out_free) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/newton_divided_difference_interpolator_unit.sv
// channel  | dir | tdata                                  | tuser
// s_*      | in  | node_x[31:0] node_y[63:32] eval_x[95:64] | mode[1:0]
// m_*      | out | value[31:0]                            | status[1:0]
//
// load, clear, full-store and no-node requests each give one word.
// an evaluation over n nodes copies the y values, fills the table with the
// 49-step shared divider and then sums the Newton form.
// one request at a time; the next is taken once the result sits in the output register.
// rst is synchronous and empties the node set; a stalled m side holds its word.
module newton_divided_difference_interpolator_unit #(
  parameter int MAX_NODES = ndd_pkg::NDD_MAX_NODES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // node_x, node_y, eval_x
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value
  output logic [1:0]  m_tuser    // status
);
  import ndd_pkg::*;

  op_t       op;
  dp_flags_t flags;

  ndd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .mode(s_tuser),
    .in_ready(s_tready), .flags(flags), .op(op)
  );

  ndd_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk(clk), .rst(rst), .op(op), .flags(flags),
    .in_x(s_tdata[31:0]), .in_y(s_tdata[63:32]), .in_eval(s_tdata[95:64]),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_value(m_tdata), .out_status(m_tuser)
  );

endmodule

// File: rtl/ndd_checker.sv
`include "newton_divided_difference_interpolator_unit_assert.svh"

module ndd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import ndd_pkg::*;

  // a stalled word stays
  `NDD_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `NDD_ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))

  // no word right after reset
  `NDD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)

  // an error word carries zero
  `NDD_ASSERT_SAME(a_err_zero, clk, rst, m_tvalid && m_tuser != ST_OK, m_tdata == '0)

  // a clear keeps the input closed until its word sits in the output register
  `NDD_ASSERT_NEXT(a_clear_busy, clk, rst,
    s_tvalid && s_tready && s_tuser == MODE_CLEAR, !s_tready)

endmodule

bind newton_divided_difference_interpolator_unit ndd_checker u_ndd_checker (.*);
